[hdl/aalpw_pkg.sv]
// Shared constants and types for the anti-aliased line pixel writer.
// No dependencies; imported by antialiased_line_pixel_writer_core.
`default_nettype none

package aalpw_pkg;

    // Frame and number format
    localparam int MAX_DIM   = 1024;
    localparam int FRAC_BITS = 16;
    localparam int DIM_W     = 11;
    localparam int COORD_W   = 10;
    localparam int SLOPE_W   = 32;
    localparam int INT_W     = 8;

    // Configuration register indexes
    localparam logic REG_NUM_ROWS = 1'b0;
    localparam logic REG_NUM_COLS = 1'b1;
    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

    // Steep case: |index*one - intercept| and the long division sizes
    localparam int NUM_W = ((COORD_W + FRAC_BITS > SLOPE_W - 1) ?
                            (COORD_W + FRAC_BITS) : (SLOPE_W - 1)) + 1;
    localparam int DVD_W = NUM_W + FRAC_BITS;
    localparam int Q_W   = NUM_W;
    localparam int MAG_W = Q_W;
    localparam int DIV_STEPS = Q_W;

    // Shallow case: product and sum widths
    localparam int PROD_W = SLOPE_W + COORD_W + 1;
    localparam int C_W    = MAG_W + 2;

    // Base pixel magnitude and frame compare width
    localparam int BM_W  = MAG_W - FRAC_BITS;
    localparam int CMP_W = ((BM_W > DIM_W) ? BM_W : DIM_W) + 1;

    // Intensity: isqrt(floor(f * 255^2)) on a 16-bit radicand
    localparam int SQ_SCALE = 65025;
    localparam int SCALE_W  = 16;
    localparam int T_W      = FRAC_BITS + SCALE_W;
    localparam int SQ_W     = 16;
    localparam int SQ_STEPS = SQ_W / 2;
    localparam int SQ_HALF  = SQ_STEPS / 2;
    localparam logic [INT_W-1:0] INT_MAX = INT_W'(255);

    // One long-division stage
    typedef struct packed {
        logic               shallow;
        logic               neg;
        logic [COORD_W-1:0] idx;
        logic [SLOPE_W-1:0] dvsr;
        logic [SLOPE_W-1:0] rem;
        logic [MAG_W-1:0]   mag;
    } div_stage_t;

    // Square root remainder and root
    typedef struct packed {
        logic [SQ_W-1:0] v;
        logic [SQ_W-1:0] r;
    } sq_t;

    // Pixel placement carried behind the divider
    typedef struct packed {
        logic               shallow;
        logic [COORD_W-1:0] idx;
        logic               v0;
        logic               v1;
        logic [COORD_W-1:0] pos0;
        logic [COORD_W-1:0] pos1;
    } place_t;

endpackage

`default_nettype wire

[hdl/antialiased_line_pixel_writer_core.sv]
// Anti-aliased line pixel writer: one step index in, up to two pixel writes out.
// Depends on aalpw_pkg (constants, stage structs).
//
// Usage:
//   Input channel (in_valid/in_ready) takes slope and intercept in signed Q16.16
//   and a step index. Output channel (out_valid/out_ready) gives zero, one or two
//   pixel writes per item; last_write marks the final write of an item. Items
//   that land fully off the frame give no writes.
//   Configuration channel (cfg_valid/cfg_ready, always ready) writes num_rows
//   (index 0) or num_cols (index 1); write only while the block is idle.
//   The path is a 3-stage front end, a 32-stage restoring divider (one quotient
//   bit per stage), three stages of placement and square root, and an output
//   register that emits the two writes of an item one after the other.
//   Throughput: one item per cycle into the pipe while the output is not stalled;
//   an item whose writes both land holds the single output channel for both.
//   Reset: pipeline empties, both frame registers return to 1024.
//   Receiver stall: the output register holds its write; each stage keeps
//   accepting until the one ahead of it is full, then the input deasserts ready.
`default_nettype none

module antialiased_line_pixel_writer_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // Input items
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic signed [aalpw_pkg::SLOPE_W-1:0]  slope,
    input  wire logic signed [aalpw_pkg::SLOPE_W-1:0]  intercept,
    input  wire logic        [aalpw_pkg::COORD_W-1:0]  step_index,
    // Pixel writes
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic             [aalpw_pkg::COORD_W-1:0]  pixel_row,
    output logic             [aalpw_pkg::COORD_W-1:0]  pixel_col,
    output logic             [aalpw_pkg::INT_W-1:0]    intensity,
    output logic                                       last_write,
    // Configuration writes
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic                                  cfg_index,
    input  wire logic        [aalpw_pkg::DIM_W-1:0]    cfg_data
);

    import aalpw_pkg::*;

    // One restoring division step: shift in a dividend bit, subtract if it fits
    function automatic div_stage_t div_step(input div_stage_t d);
        div_stage_t     o;
        logic [SLOPE_W:0] trial;
        o     = d;
        trial = {d.rem, d.mag[MAG_W-1]};
        if (!d.shallow)
        begin
            if (trial >= {1'b0, d.dvsr})
            begin
                o.rem = SLOPE_W'(trial - {1'b0, d.dvsr});
                o.mag = {d.mag[MAG_W-2:0], 1'b1};
            end
            else
            begin
                o.rem = trial[SLOPE_W-1:0];
                o.mag = {d.mag[MAG_W-2:0], 1'b0};
            end
        end
        return o;
    endfunction

    // One digit step of the integer square root
    function automatic sq_t sq_step(input sq_t q, input int k);
        sq_t           o;
        logic [SQ_W-1:0] b;
        logic [SQ_W:0]   sum;
        o   = q;
        b   = SQ_W'(1) << (SQ_W - 2 - 2 * k);
        sum = {1'b0, q.r} + {1'b0, b};
        if ({1'b0, q.v} >= sum)
        begin
            o.v = q.v - sum[SQ_W-1:0];
            o.r = (q.r >> 1) + b;
        end
        else
        begin
            o.r = q.r >> 1;
        end
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] num_rows_reg;
    logic [DIM_W-1:0] num_cols_reg;
    logic [DIM_W-1:0] rows_ext;
    logic [DIM_W-1:0] cols_ext;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= DIM_RESET;
            num_cols_reg <= DIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_NUM_ROWS: num_rows_reg <= cfg_data;
                REG_NUM_COLS: num_cols_reg <= cfg_data;
                default:      num_rows_reg <= num_rows_reg;
            endcase
        end
    end

    // Clamp the frame to the largest supported extent
    assign rows_ext = (num_rows_reg > DIM_RESET) ? DIM_RESET : num_rows_reg;
    assign cols_ext = (num_cols_reg > DIM_RESET) ? DIM_RESET : num_cols_reg;

    // ------------------------------------------------------------------
    // Stage valids and load enables (a stage loads when empty or draining)
    // ------------------------------------------------------------------
    logic a_v_reg, b_v_reg, c_v_reg, e_v_reg, f_v_reg, g_v_reg;
    logic [DIV_STEPS-1:0] div_v_reg;
    logic a_load, b_load, c_load, e_load, f_load, g_load, o_load;
    logic [DIV_STEPS:0] div_load;
    logic pend0_reg, pend1_reg;

    assign o_load = !(pend0_reg || pend1_reg) || (out_ready && !(pend0_reg && pend1_reg));
    assign g_load = !g_v_reg || o_load;
    assign f_load = !f_v_reg || g_load;
    assign e_load = !e_v_reg || f_load;

    always_comb
    begin
        div_load[DIV_STEPS] = e_load;
        for (int k = DIV_STEPS - 1; k >= 0; k--)
        begin
            div_load[k] = !div_v_reg[k] || div_load[k+1];
        end
    end

    assign c_load   = !c_v_reg || div_load[0];
    assign b_load   = !b_v_reg || c_load;
    assign a_load   = !a_v_reg || b_load;
    assign in_ready = a_load;

    // ------------------------------------------------------------------
    // Stage A: classify slope, drop items whose index is off the frame
    // ------------------------------------------------------------------
    logic [SLOPE_W-1:0] in_abs_s;
    logic               in_shallow;
    logic               in_frame;

    assign in_abs_s   = slope[SLOPE_W-1] ? ((~slope) + SLOPE_W'(1)) : slope;
    assign in_shallow = in_abs_s <= (SLOPE_W'(1) << FRAC_BITS);
    assign in_frame   = {1'b0, step_index} < (in_shallow ? cols_ext : rows_ext);

    logic signed [SLOPE_W-1:0] a_s_reg;
    logic signed [SLOPE_W-1:0] a_p_reg;
    logic        [COORD_W-1:0] a_idx_reg;
    logic        [SLOPE_W-1:0] a_abs_s_reg;
    logic                      a_shallow_reg;

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_s_reg       <= slope;
            a_p_reg       <= intercept;
            a_idx_reg     <= step_index;
            a_abs_s_reg   <= in_abs_s;
            a_shallow_reg <= in_shallow;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: shallow product and steep numerator
    // ------------------------------------------------------------------
    logic signed [NUM_W:0]    b_num_s;
    logic        [NUM_W-1:0]  b_num_mag_next;
    logic signed [PROD_W-1:0] b_prod_next;

    assign b_num_s = $signed({{(NUM_W + 1 - COORD_W - FRAC_BITS){1'b0}}, a_idx_reg,
                              {FRAC_BITS{1'b0}}})
                   - $signed({{(NUM_W + 1 - SLOPE_W){a_p_reg[SLOPE_W-1]}}, a_p_reg});
    assign b_num_mag_next = b_num_s[NUM_W] ? NUM_W'(-b_num_s) : NUM_W'(b_num_s);
    assign b_prod_next    = $signed(a_s_reg) * $signed({1'b0, a_idx_reg});

    logic signed [PROD_W-1:0]  b_prod_reg;
    logic        [NUM_W-1:0]   b_num_mag_reg;
    logic                      b_neg_reg;
    logic signed [SLOPE_W-1:0] b_p_reg;
    logic        [COORD_W-1:0] b_idx_reg;
    logic        [SLOPE_W-1:0] b_abs_s_reg;
    logic                      b_shallow_reg;

    always_ff @(posedge clk)
    begin
        if (b_load)
        begin
            b_prod_reg    <= b_prod_next;
            b_num_mag_reg <= b_num_mag_next;
            b_neg_reg     <= b_num_s[NUM_W] ^ a_s_reg[SLOPE_W-1];
            b_p_reg       <= a_p_reg;
            b_idx_reg     <= a_idx_reg;
            b_abs_s_reg   <= a_abs_s_reg;
            b_shallow_reg <= a_shallow_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: shallow coordinate magnitude, or divider setup
    // ------------------------------------------------------------------
    logic signed [C_W-1:0] c_sum;
    logic        [DVD_W-1:0] c_dvd;
    div_stage_t            c_next;
    div_stage_t            c_reg;

    assign c_sum = $signed(b_prod_reg[C_W-1:0])
                 + $signed({{(C_W - SLOPE_W){b_p_reg[SLOPE_W-1]}}, b_p_reg});
    assign c_dvd = {b_num_mag_reg, {FRAC_BITS{1'b0}}};

    always_comb
    begin
        c_next.shallow = b_shallow_reg;
        c_next.idx     = b_idx_reg;
        c_next.dvsr    = b_abs_s_reg;
        if (b_shallow_reg)
        begin
            c_next.neg = c_sum[C_W-1];
            c_next.rem = '0;
            c_next.mag = c_sum[C_W-1] ? MAG_W'(-c_sum) : MAG_W'(c_sum);
        end
        else
        begin
            c_next.neg = b_neg_reg;
            c_next.rem = SLOPE_W'(c_dvd[DVD_W-1:Q_W]);
            c_next.mag = c_dvd[Q_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_load)
        begin
            c_reg <= c_next;
        end
    end

    // ------------------------------------------------------------------
    // Divider: one quotient bit per stage
    // ------------------------------------------------------------------
    div_stage_t div_reg [DIV_STEPS];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            if (div_load[k])
            begin
                if (k == 0)
                begin
                    div_reg[k] <= div_step(c_reg);
                end
                else
                begin
                    div_reg[k] <= div_step(div_reg[k-1]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage E: base pixel, frame checks, fraction scaling
    // ------------------------------------------------------------------
    div_stage_t       dl;
    logic [BM_W-1:0]  e_bm;
    logic [CMP_W-1:0] e_bm_x;
    logic [CMP_W-1:0] e_lim_x;
    logic [CMP_W-1:0] e_pos1_x;
    logic             e_v0_next;
    logic             e_v1_next;
    logic [T_W-1:0]   e_t_next;

    assign dl       = div_reg[DIV_STEPS-1];
    assign e_bm     = dl.mag[MAG_W-1:FRAC_BITS];
    assign e_bm_x   = CMP_W'(e_bm);
    assign e_lim_x  = CMP_W'(dl.shallow ? rows_ext : cols_ext);
    assign e_pos1_x = dl.neg ? (CMP_W'(1) - e_bm_x) : (e_bm_x + CMP_W'(1));
    assign e_v0_next = (!dl.neg || (e_bm_x == '0)) && (e_bm_x < e_lim_x);
    assign e_v1_next = (!dl.neg || (e_bm_x <= CMP_W'(1))) && (e_pos1_x < e_lim_x);
    assign e_t_next  = T_W'(dl.mag[FRAC_BITS-1:0]) * T_W'(SQ_SCALE);

    logic [T_W-1:0] e_t_reg;
    place_t         e_pl_reg;

    always_ff @(posedge clk)
    begin
        if (e_load)
        begin
            e_t_reg          <= e_t_next;
            e_pl_reg.shallow <= dl.shallow;
            e_pl_reg.idx     <= dl.idx;
            e_pl_reg.v0      <= e_v0_next;
            e_pl_reg.v1      <= e_v1_next;
            e_pl_reg.pos0    <= COORD_W'(e_bm);
            e_pl_reg.pos1    <= COORD_W'(e_pos1_x);
        end
    end

    // ------------------------------------------------------------------
    // Stage F: first half of the square root
    // ------------------------------------------------------------------
    sq_t f_sq_next;

    always_comb
    begin
        f_sq_next.v = e_t_reg[T_W-1:FRAC_BITS];
        f_sq_next.r = '0;
        for (int k = 0; k < SQ_HALF; k++)
        begin
            f_sq_next = sq_step(f_sq_next, k);
        end
    end

    sq_t    f_sq_reg;
    logic   f_lowz_reg;
    place_t f_pl_reg;

    always_ff @(posedge clk)
    begin
        if (f_load)
        begin
            f_sq_reg   <= f_sq_next;
            f_lowz_reg <= (e_t_reg[FRAC_BITS-1:0] == '0);
            f_pl_reg   <= e_pl_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage G: second half of the square root, both intensities
    // ------------------------------------------------------------------
    sq_t              g_sq;
    logic [INT_W-1:0] g_a;
    logic             g_exact;

    always_comb
    begin
        g_sq = f_sq_reg;
        for (int k = SQ_HALF; k < SQ_STEPS; k++)
        begin
            g_sq = sq_step(g_sq, k);
        end
    end

    assign g_a     = g_sq.r[INT_W-1:0];
    assign g_exact = (g_sq.v == '0) && f_lowz_reg;

    logic [INT_W-1:0] g_i0_reg;
    logic [INT_W-1:0] g_i1_reg;
    place_t           g_pl_reg;

    always_ff @(posedge clk)
    begin
        if (g_load)
        begin
            g_i0_reg <= g_a;
            g_i1_reg <= INT_MAX - (g_exact ? g_a : (g_a + INT_W'(1)));
            g_pl_reg <= f_pl_reg;
        end
    end

    // ------------------------------------------------------------------
    // Valid bits for all stages
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg   <= 1'b0;
            b_v_reg   <= 1'b0;
            c_v_reg   <= 1'b0;
            div_v_reg <= '0;
            e_v_reg   <= 1'b0;
            f_v_reg   <= 1'b0;
            g_v_reg   <= 1'b0;
        end
        else
        begin
            if (a_load)
            begin
                a_v_reg <= in_valid && in_frame;
            end
            if (b_load)
            begin
                b_v_reg <= a_v_reg;
            end
            if (c_load)
            begin
                c_v_reg <= b_v_reg;
            end
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                if (div_load[k])
                begin
                    div_v_reg[k] <= (k == 0) ? c_v_reg : div_v_reg[k-1];
                end
            end
            // Drop items with no pixel on the frame
            if (e_load)
            begin
                e_v_reg <= div_v_reg[DIV_STEPS-1] && (e_v0_next || e_v1_next);
            end
            if (f_load)
            begin
                f_v_reg <= e_v_reg;
            end
            if (g_load)
            begin
                g_v_reg <= f_v_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: emit the base write, then the next-pixel write
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] row0_reg, col0_reg, row1_reg, col1_reg;
    logic [INT_W-1:0]   int0_reg, int1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend0_reg <= 1'b0;
            pend1_reg <= 1'b0;
        end
        else if (o_load)
        begin
            pend0_reg <= g_v_reg && g_pl_reg.v0;
            pend1_reg <= g_v_reg && g_pl_reg.v1;
        end
        else if (out_valid && out_ready)
        begin
            pend0_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_load)
        begin
            row0_reg <= g_pl_reg.shallow ? g_pl_reg.pos0 : g_pl_reg.idx;
            col0_reg <= g_pl_reg.shallow ? g_pl_reg.idx : g_pl_reg.pos0;
            row1_reg <= g_pl_reg.shallow ? g_pl_reg.pos1 : g_pl_reg.idx;
            col1_reg <= g_pl_reg.shallow ? g_pl_reg.idx : g_pl_reg.pos1;
            int0_reg <= g_i0_reg;
            int1_reg <= g_i1_reg;
        end
    end

    assign out_valid  = pend0_reg || pend1_reg;
    assign pixel_row  = pend0_reg ? row0_reg : row1_reg;
    assign pixel_col  = pend0_reg ? col0_reg : col1_reg;
    assign intensity  = pend0_reg ? int0_reg : int1_reg;
    assign last_write = !(pend0_reg && pend1_reg);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Divider remainder stays below the divisor through the last stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (div_v_reg[DIV_STEPS-1] && !div_reg[DIV_STEPS-1].shallow)
        |-> (div_reg[DIV_STEPS-1].rem < div_reg[DIV_STEPS-1].dvsr))
    else $error("divider remainder not below divisor");

    // The two intensities of a pixel pair add to 254 or 255
    assert property (@(posedge clk) disable iff (!rst_n)
        (pend0_reg && pend1_reg)
        |-> ((({1'b0, int0_reg} + {1'b0, int1_reg}) == 9'd254)
          || (({1'b0, int0_reg} + {1'b0, int1_reg}) == 9'd255)))
    else $error("intensity pair out of range");

    // A taken first write of a pair is followed by the final write
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_write) |=> (out_valid && last_write))
    else $error("second write of a pair lost");

endmodule

`default_nettype wire
